>>> hdl/cacn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cacn_pkg
// Shared types and constants of the address-claim node: item and result
// layouts, claim phases, result kinds and identifier fields.
// ----------------------------------------------------------------------------
package cacn_pkg;

	localparam int unsigned NAME_W  = 64;
	localparam int unsigned ADDR_W  = 8;
	localparam int unsigned WAIT_W  = 16;
	localparam int unsigned ID_W    = 29;
	localparam int unsigned LEN_W   = 4;
	localparam int unsigned DATA_W  = 64;
	localparam int unsigned WGRP_W  = 18;
	localparam int unsigned AGRP_W  = 24;
	localparam int unsigned RXGRP_W = 17;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [2:0]         PRIO_DEFAULT   = 3'd6;
	localparam logic [7:0]         PF_CLAIM       = 8'hEE;
	localparam logic [7:0]         PF_REQUEST     = 8'hEA;
	localparam logic [7:0]         PS_GLOBAL      = 8'hFF;
	localparam logic [7:0]         PF_PDU2_MIN    = 8'd240;
	localparam logic [RXGRP_W-1:0] GRP_CLAIM      = 17'h0EE00;
	localparam logic [RXGRP_W-1:0] GRP_ACK        = 17'h0E800;
	localparam logic [ADDR_W-1:0]  NULL_ADDR      = 8'd254;
	localparam logic [WAIT_W-1:0]  CLAIM_WAIT_RST = 16'd250;
	localparam logic [LEN_W-1:0]   MAX_LEN        = 4'd8;
	localparam logic [LEN_W-1:0]   CLAIM_LEN      = 4'd8;
	localparam logic [LEN_W-1:0]   REQUEST_LEN    = 4'd3;
	localparam logic [7:0]         CTL_POSITIVE   = 8'd0;
	localparam logic [7:0]         CTL_NEGATIVE   = 8'd1;

	localparam logic [CFG_IDX_W-1:0] REG_DEVICE_NAME = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PREF_ADDR   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CLAIM_WAIT  = 2'd2;

	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_FRAME   = 2'd1,
		OP_REQUEST = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		PH_UNCLAIMED = 2'd0,
		PH_CLAIMING  = 2'd1,
		PH_CLAIMED   = 2'd2,
		PH_CANNOT    = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		KIND_CLAIM     = 3'd0,
		KIND_REQUEST   = 3'd1,
		KIND_FORWARD   = 3'd2,
		KIND_ACK       = 3'd3,
		KIND_HELD      = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ACK_POSITIVE = 2'd0,
		ACK_NEGATIVE = 2'd1,
		ACK_UNKNOWN  = 2'd2
	} ack_t;

	typedef struct packed {
		logic [1:0]        op;
		logic [ID_W-1:0]   frame_id;
		logic [LEN_W-1:0]  frame_len;
		logic [DATA_W-1:0] frame_data;
		logic [WGRP_W-1:0] wanted_group;
		logic [ADDR_W-1:0] target_node;
	} item_t;

	typedef struct packed {
		kind_t             kind;
		logic [ID_W-1:0]   out_id;
		logic [LEN_W-1:0]  out_len;
		logic [DATA_W-1:0] out_data;
		ack_t              ack_code;
		logic [AGRP_W-1:0] ack_group;
		phase_t            claim_status;
		logic [ADDR_W-1:0] own_address;
		logic              last;
	} result_t;

	typedef struct packed {
		phase_t            phase;
		logic [ADDR_W-1:0] addr;
		logic [WAIT_W-1:0] wait_count;
	} node_state_t;

	typedef struct packed {
		logic [NAME_W-1:0] device_name;
		logic [ADDR_W-1:0] preferred_address;
		logic [WAIT_W-1:0] claim_wait;
	} node_cfg_t;

endpackage
`default_nettype wire

>>> hdl/cacn_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cacn_item_if / cacn_result_if
// Valid/ready channels that carry input items and result items.
// ----------------------------------------------------------------------------
interface cacn_item_if import cacn_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        op;
	logic [ID_W-1:0]   frame_id;
	logic [LEN_W-1:0]  frame_len;
	logic [DATA_W-1:0] frame_data;
	logic [WGRP_W-1:0] wanted_group;
	logic [ADDR_W-1:0] target_node;

	modport source (output valid, op, frame_id, frame_len, frame_data, wanted_group,
		target_node, input ready);
	modport sink (input valid, op, frame_id, frame_len, frame_data, wanted_group,
		target_node, output ready);
endinterface

interface cacn_result_if import cacn_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [2:0]        kind;
	logic [ID_W-1:0]   out_id;
	logic [LEN_W-1:0]  out_len;
	logic [DATA_W-1:0] out_data;
	logic [1:0]        ack_code;
	logic [AGRP_W-1:0] ack_group;
	logic [1:0]        claim_status;
	logic [ADDR_W-1:0] own_address;
	logic              last;

	modport source (output valid, kind, out_id, out_len, out_data, ack_code, ack_group,
		claim_status, own_address, last, input ready);
	modport sink (input valid, kind, out_id, out_len, out_data, ack_code, ack_group,
		claim_status, own_address, last, output ready);
endinterface
`default_nettype wire

>>> hdl/cacn_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cacn_step
// Next-state and result logic for one item: claim timing, contention,
// frame classification and request building.
// ----------------------------------------------------------------------------
module cacn_step import cacn_pkg::*; (
	input  node_cfg_t   cfg,
	input  node_state_t st,
	input  item_t       item,
	output node_state_t nxt,
	output result_t     res,
	output logic        res_valid
);

	logic [7:0]         rx_pf;
	logic [RXGRP_W-1:0] rx_grp;
	logic [7:0]         ctl;

	always_comb begin
		rx_pf  = item.frame_id[23:16];
		rx_grp = item.frame_id[24:8];
		if (rx_pf < PF_PDU2_MIN) begin
			rx_grp[7:0] = 8'd0;
		end
		ctl = item.frame_data[7:0];
	end

	always_comb begin
		nxt       = st;
		res       = '0;
		res_valid = 1'b0;
		unique case (op_t'(item.op))
			OP_TICK: begin
				if (st.phase == PH_UNCLAIMED) begin
					nxt.addr       = cfg.preferred_address;
					nxt.wait_count = '0;
					nxt.phase      = PH_CLAIMING;
					res_valid      = 1'b1;
					res.kind       = KIND_CLAIM;
					res.out_id     = {PRIO_DEFAULT, 2'b00, PF_CLAIM, PS_GLOBAL,
						cfg.preferred_address};
					res.out_len    = CLAIM_LEN;
					res.out_data   = cfg.device_name;
				end else if (st.phase == PH_CLAIMING) begin
					if (st.wait_count >= cfg.claim_wait) begin
						nxt.phase = PH_CLAIMED;
					end else begin
						nxt.wait_count = st.wait_count + 1'b1;
					end
				end
			end
			OP_FRAME: begin
				if (rx_grp == GRP_CLAIM) begin
					if ((st.phase == PH_CLAIMING || st.phase == PH_CLAIMED) &&
							item.frame_id[7:0] == st.addr) begin
						if (cfg.device_name < item.frame_data) begin
							res_valid    = 1'b1;
							res.kind     = KIND_CLAIM;
							res.out_id   = {PRIO_DEFAULT, 2'b00, PF_CLAIM, PS_GLOBAL, st.addr};
							res.out_len  = CLAIM_LEN;
							res.out_data = cfg.device_name;
						end else begin
							nxt.phase = PH_CANNOT;
							nxt.addr  = NULL_ADDR;
						end
					end
				end else if (rx_grp == GRP_ACK) begin
					res_valid     = 1'b1;
					res.kind      = KIND_ACK;
					res.ack_group = item.frame_data[63:40];
					if (ctl == CTL_POSITIVE) begin
						res.ack_code = ACK_POSITIVE;
					end else if (ctl == CTL_NEGATIVE) begin
						res.ack_code = ACK_NEGATIVE;
					end else begin
						res.ack_code = ACK_UNKNOWN;
					end
				end else begin
					res_valid    = 1'b1;
					res.kind     = KIND_FORWARD;
					res.out_id   = item.frame_id;
					res.out_len  = (item.frame_len > MAX_LEN) ? MAX_LEN : item.frame_len;
					res.out_data = item.frame_data;
				end
			end
			OP_REQUEST: begin
				res_valid = 1'b1;
				if (st.phase == PH_CLAIMED) begin
					res.kind     = KIND_REQUEST;
					res.out_id   = {PRIO_DEFAULT, 2'b00, PF_REQUEST, item.target_node, st.addr};
					res.out_len  = REQUEST_LEN;
					res.out_data = {{(DATA_W-WGRP_W){1'b0}}, item.wanted_group};
				end else begin
					res.kind = KIND_HELD;
				end
			end
			default: begin
			end
		endcase
		res.claim_status = nxt.phase;
		res.own_address  = nxt.addr;
		res.last         = 1'b1;
		if (!res_valid) begin
			res = '0;
		end
	end

endmodule
`default_nettype wire

>>> hdl/can_address_claim_node_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// can_address_claim_node_unit
// Source-address claim node for an extended-identifier vehicle network.
// ----------------------------------------------------------------------------
// An item is registered at acceptance; its result item is registered in the result
// register when that item leaves the input register.
// Throughput: one item per cycle unless the result register stalls; each item gives at most one result item.
// The input register advances whenever the result register is free or taken.
// Reset: phase unclaimed, address 254, wait count zero, claim_wait 250,
// device_name and preferred_address zero; both channel stages empty.
// ----------------------------------------------------------------------------
module can_address_claim_node_unit import cacn_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [NAME_W-1:0]    cfg_wdata,
	cacn_item_if.sink                 items,
	cacn_result_if.source             results
);

	node_cfg_t   cfg_q;
	node_state_t st_q;
	node_state_t st_nxt;
	item_t       item_s1;
	logic        valid_s1;
	result_t     res;
	logic        res_valid;
	result_t     out_q;
	logic        out_valid_q;
	logic        adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_name       <= '0;
			cfg_q.preferred_address <= '0;
			cfg_q.claim_wait        <= CLAIM_WAIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEVICE_NAME: cfg_q.device_name       <= cfg_wdata;
				REG_PREF_ADDR:   cfg_q.preferred_address <= cfg_wdata[ADDR_W-1:0];
				REG_CLAIM_WAIT:  cfg_q.claim_wait        <= cfg_wdata[WAIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	cacn_step u_step (
		.cfg       (cfg_q),
		.st        (st_q),
		.item      (item_s1),
		.nxt       (st_nxt),
		.res       (res),
		.res_valid (res_valid)
	);

	assign adv_s1      = valid_s1 && (!res_valid || !out_valid_q || results.ready);
	assign items.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.ready && items.valid) begin
			item_s1.op           <= items.op;
			item_s1.frame_id     <= items.frame_id;
			item_s1.frame_len    <= items.frame_len;
			item_s1.frame_data   <= items.frame_data;
			item_s1.wanted_group <= items.wanted_group;
			item_s1.target_node  <= items.target_node;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase      <= PH_UNCLAIMED;
			st_q.addr       <= NULL_ADDR;
			st_q.wait_count <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (adv_s1) begin
				st_q <= st_nxt;
			end
			if (adv_s1 && res_valid) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && res_valid) begin
			out_q <= res;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.kind         = out_q.kind;
	assign results.out_id       = out_q.out_id;
	assign results.out_len      = out_q.out_len;
	assign results.out_data     = out_q.out_data;
	assign results.ack_code     = out_q.ack_code;
	assign results.ack_group    = out_q.ack_group;
	assign results.claim_status = out_q.claim_status;
	assign results.own_address  = out_q.own_address;
	assign results.last         = out_q.last;

	// A node that lost contention holds the null address for good.
	a_cannot_null: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase == PH_CANNOT |-> st_q.addr == NULL_ADDR)
		else $error("lost node does not hold the null address");

	a_cannot_final: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase == PH_CANNOT |=> st_q.phase == PH_CANNOT)
		else $error("lost node left its final phase");

	a_request_claimed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.kind == KIND_REQUEST |-> out_q.claim_status == PH_CLAIMED)
		else $error("request sent without a claimed address");

	a_claim_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.kind == KIND_CLAIM |->
			(out_q.claim_status == PH_CLAIMING || out_q.claim_status == PH_CLAIMED))
		else $error("claim sent outside the claiming or claimed phase");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !results.ready |-> !(adv_s1 && res_valid))
		else $error("result register overwritten while stalled");

endmodule
`default_nettype wire

>>> bench/can_address_claim_node_unit_tb.sv
// ----------------------------------------------------------------------------
// can_address_claim_node_unit_tb
// Drives ticks, received frames and send requests into the address-claim
// node under random source gaps and sink stalls. A predictor tracks the claim
// phase, the source address and the wait count and queues the expected result
// items. Each result item is checked field by field against that queue.
// ----------------------------------------------------------------------------
module can_address_claim_node_unit_tb import cacn_pkg::*; ();

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 6;
	localparam int ROUND_ITEMS = 300;
	localparam int TAIL_ITEMS = 150;
	localparam logic [NAME_W-1:0] NAME_MAX = '1;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [NAME_W-1:0] cfg_wdata;

	cacn_item_if items();
	cacn_result_if results();

	can_address_claim_node_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.items(items),
		.results(results)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	phase_t node_phase;
	logic [ADDR_W-1:0] node_addr;
	logic [WAIT_W-1:0] node_wait;
	logic [NAME_W-1:0] name_reg;
	logic [ADDR_W-1:0] pref_reg;
	logic [WAIT_W-1:0] wait_reg;
	result_t due_results[$];
	int mismatches = 0;
	bit quiet = 1'b0;

	function automatic result_t status_result(kind_t k);
		result_t r;
		r = '0;
		r.kind = k;
		r.claim_status = node_phase;
		r.own_address = node_addr;
		r.last = 1'b1;
		return r;
	endfunction

	function automatic void push_claim();
		result_t r;
		r = status_result(KIND_CLAIM);
		r.out_id = {PRIO_DEFAULT, 2'b00, PF_CLAIM, PS_GLOBAL, node_addr};
		r.out_len = CLAIM_LEN;
		r.out_data = name_reg;
		due_results.push_back(r);
	endfunction

	function automatic void node_step(item_t it);
		result_t r;
		logic [7:0] pf;
		logic [RXGRP_W-1:0] grp;
		pf = it.frame_id[23:16];
		grp = it.frame_id[24:8];
		if (pf < PF_PDU2_MIN)
			grp[7:0] = '0;
		case (op_t'(it.op))
			OP_TICK: begin
				if (node_phase == PH_UNCLAIMED) begin
					node_addr = pref_reg;
					node_wait = '0;
					node_phase = PH_CLAIMING;
					push_claim();
				end else if (node_phase == PH_CLAIMING) begin
					if (node_wait >= wait_reg)
						node_phase = PH_CLAIMED;
					else
						node_wait = node_wait + 1'b1;
				end
			end
			OP_FRAME: begin
				if (grp == GRP_CLAIM) begin
					if ((node_phase == PH_CLAIMING || node_phase == PH_CLAIMED) &&
							it.frame_id[7:0] == node_addr) begin
						if (name_reg < it.frame_data) begin
							push_claim();
						end else begin
							node_phase = PH_CANNOT;
							node_addr = NULL_ADDR;
						end
					end
				end else if (grp == GRP_ACK) begin
					r = status_result(KIND_ACK);
					case (it.frame_data[7:0])
						CTL_POSITIVE: r.ack_code = ACK_POSITIVE;
						CTL_NEGATIVE: r.ack_code = ACK_NEGATIVE;
						default: r.ack_code = ACK_UNKNOWN;
					endcase
					r.ack_group = it.frame_data[63:40];
					due_results.push_back(r);
				end else begin
					r = status_result(KIND_FORWARD);
					r.out_id = it.frame_id;
					r.out_len = (it.frame_len > MAX_LEN) ? MAX_LEN : it.frame_len;
					r.out_data = it.frame_data;
					due_results.push_back(r);
				end
			end
			OP_REQUEST: begin
				if (node_phase == PH_CLAIMED) begin
					r = status_result(KIND_REQUEST);
					r.out_id = {PRIO_DEFAULT, 2'b00, PF_REQUEST, it.target_node, node_addr};
					r.out_len = REQUEST_LEN;
					r.out_data = DATA_W'(it.wanted_group);
					due_results.push_back(r);
				end else begin
					due_results.push_back(status_result(KIND_HELD));
				end
			end
			default: ;
		endcase
	endfunction

	function automatic item_t noise_item();
		item_t it;
		it.op = 2'($urandom_range(0, 3));
		it.frame_id = ID_W'($urandom);
		it.frame_len = LEN_W'($urandom_range(0, 15));
		it.frame_data = {$urandom, $urandom};
		it.wanted_group = WGRP_W'($urandom);
		it.target_node = ADDR_W'($urandom);
		return it;
	endfunction

	function automatic item_t tick_item();
		item_t it;
		it = noise_item();
		it.op = OP_TICK;
		return it;
	endfunction

	function automatic item_t idle_op_item();
		item_t it;
		it = noise_item();
		it.op = OP_NONE;
		return it;
	endfunction

	function automatic item_t request_item(logic [WGRP_W-1:0] grp, logic [ADDR_W-1:0] dst);
		item_t it;
		it = noise_item();
		it.op = OP_REQUEST;
		it.wanted_group = grp;
		it.target_node = dst;
		return it;
	endfunction

	function automatic item_t frame_item(logic [ID_W-1:0] fid, logic [LEN_W-1:0] len,
			logic [DATA_W-1:0] data);
		item_t it;
		it = noise_item();
		it.op = OP_FRAME;
		it.frame_id = fid;
		it.frame_len = len;
		it.frame_data = data;
		return it;
	endfunction

	function automatic item_t claim_frame(logic [ADDR_W-1:0] sa, logic [NAME_W-1:0] rival);
		return frame_item({4'($urandom), GRP_CLAIM[16:8], 8'($urandom), sa},
			LEN_W'($urandom_range(0, 15)), rival);
	endfunction

	function automatic item_t ack_frame(logic [7:0] ctl, logic [AGRP_W-1:0] grp);
		return frame_item({4'($urandom), GRP_ACK[16:8], 8'($urandom), 8'($urandom)},
			LEN_W'($urandom_range(0, 15)), {grp, 32'($urandom), ctl});
	endfunction

	// Claims aimed at our address always carry a higher name, so the node keeps
	// defending until the lost-contention test.
	function automatic item_t random_item();
		item_t it;
		int pick;
		logic [NAME_W-1:0] rival;
		logic [ADDR_W-1:0] target;
		logic [7:0] ctl;
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			it = tick_item();
		end else if (pick < 45) begin
			it = request_item(WGRP_W'($urandom), ADDR_W'($urandom));
		end else if (pick < 58) begin
			target = node_addr;
			if (name_reg == NAME_MAX) begin
				target = node_addr ^ 8'h80;
				rival = {$urandom, $urandom};
			end else begin
				case ($urandom_range(0, 2))
					0: rival = name_reg + 1'b1;
					1: rival = NAME_MAX;
					default: rival = name_reg + 1'b1 + ({$urandom, $urandom} % (NAME_MAX - name_reg));
				endcase
			end
			it = claim_frame(target, rival);
		end else if (pick < 63) begin
			it = claim_frame(node_addr ^ 8'($urandom_range(1, 255)), {$urandom, $urandom});
		end else if (pick < 73) begin
			case ($urandom_range(0, 2))
				0: ctl = CTL_POSITIVE;
				1: ctl = CTL_NEGATIVE;
				default: ctl = 8'($urandom);
			endcase
			it = ack_frame(ctl, AGRP_W'($urandom));
		end else if (pick < 97) begin
			it = noise_item();
			it.op = OP_FRAME;
			if (it.frame_id[24:16] == GRP_CLAIM[16:8])
				it.frame_id[24] = 1'b1;
		end else begin
			it = idle_op_item();
		end
		return it;
	endfunction

	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
		end
	endfunction

	task automatic send_item(input item_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			items.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		items.valid <= 1'b1;
		items.op <= it.op;
		items.frame_id <= it.frame_id;
		items.frame_len <= it.frame_len;
		items.frame_data <= it.frame_data;
		items.wanted_group <= it.wanted_group;
		items.target_node <= it.target_node;
		@(posedge clk);
		while (items.ready !== 1'b1)
			@(posedge clk);
		node_step(it);
	endtask

	task automatic settle();
		items.valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [NAME_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (index)
			REG_DEVICE_NAME: name_reg = value;
			REG_PREF_ADDR: pref_reg = value[ADDR_W-1:0];
			REG_CLAIM_WAIT: wait_reg = value[WAIT_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic apply_settings(input logic [NAME_W-1:0] dev_name,
			input logic [ADDR_W-1:0] addr, input logic [WAIT_W-1:0] claim_ticks);
		write_reg(REG_DEVICE_NAME, dev_name);
		write_reg(REG_PREF_ADDR, NAME_W'(addr));
		write_reg(REG_CLAIM_WAIT, NAME_W'(claim_ticks));
	endtask

	task automatic run_random(input int count);
		int sent;
		item_t it;
		sent = 0;
		while (sent < count) begin
			it = random_item();
			send_item(it);
			if (it.op != OP_NONE)
				sent++;
		end
	endtask

	// Reset configuration, nothing claimed yet: claims are ignored and
	// requests are held.
	task automatic test_before_claim();
		send_item(request_item('1, 8'hFF));
		send_item(claim_frame(NULL_ADDR, NAME_MAX));
		send_item(ack_frame(CTL_POSITIVE, '1));
		send_item(ack_frame(CTL_NEGATIVE, '0));
		send_item(ack_frame(8'hFF, 24'h5A5A5A));
		send_item(frame_item('1, 4'hF, '1));
		send_item(frame_item('0, 4'd0, '0));
		send_item(idle_op_item());
		settle();
	endtask

	task automatic test_claim_timing();
		apply_settings('0, 8'd253, 16'hFFFF);
		send_item(tick_item());
		send_item(request_item(18'h15555, 8'h00));
		send_item(claim_frame(8'd253, 64'd1));
		send_item(claim_frame(8'd252, '0));
		repeat (4) send_item(tick_item());
		send_item(request_item(18'h2AAAA, 8'hFF));
		settle();
		// The wait count now stands at four; with a limit of six the third
		// tick claims the address.
		write_reg(REG_CLAIM_WAIT, NAME_W'(6));
		send_item(tick_item());
		send_item(tick_item());
		send_item(request_item('1, 8'hFF));
		send_item(tick_item());
		send_item(request_item('1, 8'hFF));
		send_item(request_item('0, 8'h00));
		send_item(claim_frame(8'd253, NAME_MAX));
		settle();
	endtask

	task automatic test_claimed_traffic();
		for (int round = 0; round < 5; round++) begin
			case (round)
				0: apply_settings('0, 8'd0, 16'd0);
				1: apply_settings(NAME_MAX - 1'b1, 8'd253, 16'hFFFF);
				default: apply_settings({$urandom, $urandom}, 8'($urandom_range(0, 253)),
					16'($urandom));
			endcase
			run_random(ROUND_ITEMS);
			settle();
		end
	endtask

	// An equal name loses, and the node gives up its address for good.
	task automatic test_lost_contention();
		apply_settings(NAME_MAX, 8'd17, CLAIM_WAIT_RST);
		send_item(claim_frame(node_addr, NAME_MAX));
		send_item(request_item('1, 8'hFF));
		send_item(tick_item());
		send_item(claim_frame(NULL_ADDR, '0));
		send_item(ack_frame(CTL_NEGATIVE, 24'h00FECA));
		send_item(frame_item(29'h18FEF100, 4'd9, 64'h0123456789ABCDEF));
		run_random(TAIL_ITEMS);
		settle();
	endtask

	initial begin : result_monitor
		result_t want;
		int stall;
		stall = 0;
		results.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && results.valid === 1'b1 && results.ready === 1'b1) begin
				if (due_results.size() == 0) begin
					mismatches++;
					$display("%0t: result item with none expected, kind %0h, id %0h",
						$time, results.kind, results.out_id);
				end else begin
					want = due_results.pop_front();
					check_field("kind", 64'(want.kind), 64'(results.kind));
					check_field("out_id", 64'(want.out_id), 64'(results.out_id));
					check_field("out_len", 64'(want.out_len), 64'(results.out_len));
					check_field("out_data", want.out_data, results.out_data);
					check_field("ack_code", 64'(want.ack_code), 64'(results.ack_code));
					check_field("ack_group", 64'(want.ack_group), 64'(results.ack_group));
					check_field("claim_status", 64'(want.claim_status),
						64'(results.claim_status));
					check_field("own_address", 64'(want.own_address),
						64'(results.own_address));
					check_field("last", 64'(want.last), 64'(results.last));
				end
			end
			if (quiet) begin
				results.ready <= 1'b1;
			end else if (stall > 0) begin
				results.ready <= 1'b0;
				stall--;
			end else begin
				results.ready <= 1'b1;
				stall = pick_gap();
			end
		end
	end

	initial begin : quiet_spells
		forever begin
			repeat (64) @(posedge clk);
			quiet <= ($urandom_range(0, 3) == 0);
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((items.valid === 1'b1 && items.ready === 1'b1) ||
					(results.valid === 1'b1 && results.ready === 1'b1))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		items.valid <= 1'b0;
		items.op <= '0;
		items.frame_id <= '0;
		items.frame_len <= '0;
		items.frame_data <= '0;
		items.wanted_group <= '0;
		items.target_node <= '0;
		node_phase = PH_UNCLAIMED;
		node_addr = NULL_ADDR;
		node_wait = '0;
		name_reg = '0;
		pref_reg = '0;
		wait_reg = CLAIM_WAIT_RST;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_before_claim();
		test_claim_timing();
		test_claimed_traffic();
		test_lost_contention();
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
